>>> src/tbim_pkg.sv
package tbim_pkg;

	localparam int MOM_W      = 20;
	localparam int P_W        = 19;
	localparam int COS_W      = 16;
	localparam int DM_W       = 16;
	localparam int HL_W       = 18;
	localparam int BW_W       = 12;
	localparam int MASS_W     = 18;
	localparam int CODE_W     = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	localparam logic [DM_W-1:0] DM_RST   = 16'd2233;
	localparam logic [P_W-1:0]  PDEF_RST = 19'd3200;
	localparam logic [P_W-1:0]  PLIM_RST = 19'd160000;
	localparam logic [HL_W-1:0] HLOW_RST = 18'd6400;
	localparam logic [BW_W-1:0] BWID_RST = 12'd64;

	localparam logic [MASS_W-1:0] MASS_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DAUGHTER_MASS    = 3'd0,
		REG_DEFAULT_MOMENTUM = 3'd1,
		REG_MOMENTUM_LIMIT   = 3'd2,
		REG_HIST_LOW         = 3'd3,
		REG_BIN_WIDTH        = 3'd4
	} cfg_reg_t;

endpackage

>>> src/tbim_ifs.sv
interface tbim_pair_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [tbim_pkg::MOM_W-1:0]    momentum_first;
	logic signed [tbim_pkg::COS_W-1:0]    dir_x_first;
	logic signed [tbim_pkg::COS_W-1:0]    dir_y_first;
	logic signed [tbim_pkg::COS_W-1:0]    dir_z_first;
	logic signed [tbim_pkg::MOM_W-1:0]    momentum_second;
	logic signed [tbim_pkg::COS_W-1:0]    dir_x_second;
	logic signed [tbim_pkg::COS_W-1:0]    dir_y_second;
	logic signed [tbim_pkg::COS_W-1:0]    dir_z_second;

	modport source (output valid, momentum_first, dir_x_first, dir_y_first, dir_z_first,
		momentum_second, dir_x_second, dir_y_second, dir_z_second, input ready);
	modport sink (input valid, momentum_first, dir_x_first, dir_y_first, dir_z_first,
		momentum_second, dir_x_second, dir_y_second, dir_z_second, output ready);
endinterface

interface tbim_result_if;
	logic                          valid;
	logic                          ready;
	logic [tbim_pkg::MASS_W-1:0]   pair_mass;
	logic                          mass_valid;
	logic [tbim_pkg::CODE_W-1:0]   bin_code;

	modport source (output valid, pair_mass, mass_valid, bin_code, input ready);
	modport sink (input valid, pair_mass, mass_valid, bin_code, output ready);
endinterface

interface tbim_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tbim_pkg::CFG_IDX_W-1:0]    idx;
	logic [tbim_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

>>> src/tbim_isqrt_pipe.sv
module tbim_isqrt_pipe #(
	parameter int RAD_W = 44,
	parameter int LANES = 1,
	parameter int SB_W  = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [LANES-1:0][RAD_W-1:0]       in_rad,
	input  logic [SB_W-1:0]                   in_sb,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [LANES-1:0][RAD_W/2-1:0]     out_root,
	output logic [SB_W-1:0]                   out_sb
);
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int N      = ROOT_W;

	logic [N-1:0]                         v_q;
	logic [N-1:0]                         en;
	logic [LANES-1:0][REM_W-1:0]          rem_s  [N];
	logic [LANES-1:0][ROOT_W-1:0]         root_s [N];
	logic [LANES-1:0][RAD_W-1:0]          rad_s  [N];
	logic [SB_W-1:0]                      sb_s   [N];

	// One root bit per stage, most significant first.
	for (genvar k = 0; k < N; k++) begin : g_stg
		logic                         cur_v;
		logic [LANES-1:0][REM_W-1:0]  cur_rem;
		logic [LANES-1:0][ROOT_W-1:0] cur_root;
		logic [LANES-1:0][RAD_W-1:0]  cur_rad;
		logic [SB_W-1:0]              cur_sb;
		logic [LANES-1:0][REM_W-1:0]  nxt_rem;
		logic [LANES-1:0][ROOT_W-1:0] nxt_root;
		logic                         down_en;

		if (k == 0) begin : g_first
			assign cur_v    = in_valid;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_rad  = in_rad;
			assign cur_sb   = in_sb;
		end else begin : g_rest
			assign cur_v    = v_q[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_root = root_s[k-1];
			assign cur_rad  = rad_s[k-1];
			assign cur_sb   = sb_s[k-1];
		end

		if (k == N - 1) begin : g_last
			assign down_en = out_ready;
		end else begin : g_mid
			assign down_en = en[k+1];
		end

		assign en[k] = !v_q[k] || down_en;

		always_comb begin
			logic [REM_W-1:0] r2;
			logic [REM_W-1:0] trial;
			for (int l = 0; l < LANES; l++) begin
				r2    = {cur_rem[l][REM_W-3:0], cur_rad[l][RAD_W-1 -: 2]};
				trial = {cur_root[l], 2'b01};
				if (r2 >= trial) begin
					nxt_rem[l]  = r2 - trial;
					nxt_root[l] = {cur_root[l][ROOT_W-2:0], 1'b1};
				end else begin
					nxt_rem[l]  = r2;
					nxt_root[l] = {cur_root[l][ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en[k]) begin
				v_q[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && cur_v) begin
				rem_s[k]  <= nxt_rem;
				root_s[k] <= nxt_root;
				for (int l = 0; l < LANES; l++) begin
					rad_s[k][l] <= {cur_rad[l][RAD_W-3:0], 2'b00};
				end
				sb_s[k]   <= cur_sb;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[N-1];
	assign out_root  = root_s[N-1];
	assign out_sb    = sb_s[N-1];

endmodule

>>> src/two_body_invariant_mass.sv
// Pipeline from request acceptance to result valid: 5 front stages, 22 energy root stages,
// 3 mass-square stages, 23 mass root stages, 1 binning stage, one divider stage per quotient
// bit (QB = clog2(NUM_BINS) and at least 1), 1 output stage.
// Throughput: one pair per cycle while result.ready is high; a stage stalls only if it holds data.
// Reset (arst_n low, asynchronous): all stage valid bits clear, config registers go to defaults.
module two_body_invariant_mass #(
	parameter int NUM_BINS = 50
) (
	input  logic           clk,
	input  logic           arst_n,
	tbim_pair_if.sink      pair,
	tbim_result_if.source  result,
	tbim_cfg_if.sink       cfg
);
	// Quotient bits needed for bin index below NUM_BINS
	localparam int QB       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int MASS_IW  = 22;   // unsaturated mass width
	localparam int NBW_W    = 21;   // NUM_BINS * bin width
	localparam logic [8:0] OVF_CODE = 9'(NUM_BINS + 1);

	// ---------------------------------------------------------------------
	// Configuration registers: always ready; the block does not enforce that they are written only while idle
	// ---------------------------------------------------------------------
	logic [tbim_pkg::DM_W-1:0] dmass_q;
	logic [tbim_pkg::P_W-1:0]  pdef_q;
	logic [tbim_pkg::P_W-1:0]  plim_q;
	logic [tbim_pkg::HL_W-1:0] hlow_q;
	logic [tbim_pkg::BW_W-1:0] bwid_q;
	logic [tbim_pkg::BW_W-1:0] wd_q;    // bin width with zero read as one
	logic [NBW_W-1:0]          nbw_q;   // upper histogram span

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmass_q <= tbim_pkg::DM_RST;
			pdef_q  <= tbim_pkg::PDEF_RST;
			plim_q  <= tbim_pkg::PLIM_RST;
			hlow_q  <= tbim_pkg::HLOW_RST;
			bwid_q  <= tbim_pkg::BWID_RST;
		end else if (cfg.valid) begin
			unique case (tbim_pkg::cfg_reg_t'(cfg.idx))
				tbim_pkg::REG_DAUGHTER_MASS:    dmass_q <= cfg.data[tbim_pkg::DM_W-1:0];
				tbim_pkg::REG_DEFAULT_MOMENTUM: pdef_q  <= cfg.data[tbim_pkg::P_W-1:0];
				tbim_pkg::REG_MOMENTUM_LIMIT:   plim_q  <= cfg.data[tbim_pkg::P_W-1:0];
				tbim_pkg::REG_HIST_LOW:         hlow_q  <= cfg.data[tbim_pkg::HL_W-1:0];
				tbim_pkg::REG_BIN_WIDTH:        bwid_q  <= cfg.data[tbim_pkg::BW_W-1:0];
				default: ;
			endcase
		end
	end

	// Derived histogram constants, settled long before any request reaches binning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_q  <= tbim_pkg::BWID_RST;
			nbw_q <= NBW_W'(NUM_BINS) * NBW_W'(tbim_pkg::BWID_RST);
		end else begin
			wd_q  <= (bwid_q == '0) ? tbim_pkg::BW_W'(1) : bwid_q;
			nbw_q <= NBW_W'(NUM_BINS) * NBW_W'((bwid_q == '0) ? tbim_pkg::BW_W'(1) : bwid_q);
		end
	end

	// ---------------------------------------------------------------------
	// Front section S1..S5: clean momenta, products, components, squares
	// ---------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic e_in_ready;

	assign en_s5 = !v_s5 || e_in_ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pair.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pair.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// S1: replace non-positive or out-of-range momenta by the default
	logic [tbim_pkg::P_W-1:0]          p1_s1, p2_s1;
	logic signed [tbim_pkg::COS_W-1:0] cos_s1 [6];
	logic [tbim_pkg::P_W-1:0]          p1_cl, p2_cl;

	function automatic logic [tbim_pkg::P_W-1:0] clean_mom(
		input logic signed [tbim_pkg::MOM_W-1:0] raw,
		input logic [tbim_pkg::P_W-1:0]          lim,
		input logic [tbim_pkg::P_W-1:0]          dflt
	);
		logic bad;
		bad = raw[tbim_pkg::MOM_W-1] || (raw == '0) || (raw[tbim_pkg::P_W-1:0] >= lim);
		return bad ? dflt : raw[tbim_pkg::P_W-1:0];
	endfunction

	assign p1_cl = clean_mom(pair.momentum_first, plim_q, pdef_q);
	assign p2_cl = clean_mom(pair.momentum_second, plim_q, pdef_q);

	always_ff @(posedge clk) begin
		if (en_s1 && pair.valid) begin
			p1_s1     <= p1_cl;
			p2_s1     <= p2_cl;
			cos_s1[0] <= pair.dir_x_first;
			cos_s1[1] <= pair.dir_y_first;
			cos_s1[2] <= pair.dir_z_first;
			cos_s1[3] <= pair.dir_x_second;
			cos_s1[4] <= pair.dir_y_second;
			cos_s1[5] <= pair.dir_z_second;
		end
	end

	// S2: six p*cos products, p^2 for each track and m^2
	logic signed [35:0] prod_s2 [6];
	logic [37:0]        pp1_s2, pp2_s2;
	logic [31:0]        mm_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			for (int i = 0; i < 6; i++) begin
				prod_s2[i] <= $signed({1'b0, (i < 3) ? p1_s1 : p2_s1}) * cos_s1[i];
			end
			pp1_s2 <= p1_s1 * p1_s1;
			pp2_s2 <= p2_s1 * p2_s1;
			mm_s2  <= dmass_q * dmass_q;
		end
	end

	// S3: round components half up to 1/64 MeV, sum per axis, form energy radicands
	logic signed [24:0] sum_s3 [3];
	logic [43:0]        rad1_s3, rad2_s3, rad1_s4, rad2_s4, rad1_s5, rad2_s5;
	logic signed [23:0] comp [6];

	always_comb begin
		logic signed [36:0] rnd;
		for (int i = 0; i < 6; i++) begin
			rnd     = {prod_s2[i][35], prod_s2[i]} + 37'sd2048;
			comp[i] = rnd[35:12];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int a = 0; a < 3; a++) begin
				sum_s3[a] <= {comp[a][23], comp[a]} + {comp[a+3][23], comp[a+3]};
			end
			rad1_s3 <= {1'b0, {1'b0, pp1_s2} + {7'b0, mm_s2}, 4'b0};
			rad2_s3 <= {1'b0, {1'b0, pp2_s2} + {7'b0, mm_s2}, 4'b0};
		end
	end

	// S4: square the summed components
	logic [47:0] sq_s4 [3];
	logic [23:0] mag [3];

	always_comb begin
		logic signed [24:0] ng;
		for (int a = 0; a < 3; a++) begin
			ng     = -sum_s3[a];
			mag[a] = sum_s3[a][24] ? ng[23:0] : sum_s3[a][23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int a = 0; a < 3; a++) begin
				sq_s4[a] <= mag[a] * mag[a];
			end
			rad1_s4 <= rad1_s3;
			rad2_s4 <= rad2_s3;
		end
	end

	// S5: total squared momentum
	logic [49:0] psq_s5;

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			psq_s5  <= {2'b0, sq_s4[0]} + {2'b0, sq_s4[1]} + {2'b0, sq_s4[2]};
			rad1_s5 <= rad1_s4;
			rad2_s5 <= rad2_s4;
		end
	end

	// ---------------------------------------------------------------------
	// Energy roots: both tracks side by side, squared momentum rides along
	// ---------------------------------------------------------------------
	logic              e_out_valid, e_out_ready;
	logic [1:0][21:0]  e_root;
	logic [49:0]       e_psq;

	tbim_isqrt_pipe #(.RAD_W(44), .LANES(2), .SB_W(50)) u_esqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.in_ready (e_in_ready),
		.in_rad   ({rad2_s5, rad1_s5}),
		.in_sb    (psq_s5),
		.out_valid(e_out_valid),
		.out_ready(e_out_ready),
		.out_root (e_root),
		.out_sb   (e_psq)
	);

	// ---------------------------------------------------------------------
	// Mid section S6..S8: total energy, its square, squared mass
	// ---------------------------------------------------------------------
	logic v_s6, v_s7, v_s8;
	logic en_s6, en_s7, en_s8;
	logic m_in_ready;

	assign en_s8 = !v_s8 || m_in_ready;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign e_out_ready = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s6) v_s6 <= e_out_valid;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	logic [22:0] et_s6;
	logic [49:0] psq_s6, psq_s7;
	logic [45:0] e2_s7;
	logic [45:0] m2_s8;
	logic        neg_s8;
	logic [49:0] m2_full;

	assign m2_full = {4'b0, e2_s7} - psq_s7;

	always_ff @(posedge clk) begin
		if (en_s6 && e_out_valid) begin
			et_s6  <= {1'b0, e_root[0]} + {1'b0, e_root[1]};
			psq_s6 <= e_psq;
		end
		if (en_s7 && v_s6) begin
			e2_s7  <= et_s6 * et_s6;
			psq_s7 <= psq_s6;
		end
		if (en_s8 && v_s7) begin
			// Negative squared mass: take the root of zero and flag it
			neg_s8 <= {4'b0, e2_s7} < psq_s7;
			m2_s8  <= ({4'b0, e2_s7} < psq_s7) ? '0 : m2_full[45:0];
		end
	end

	// ---------------------------------------------------------------------
	// Mass root
	// ---------------------------------------------------------------------
	logic              m_out_valid, m_out_ready;
	logic [0:0][22:0]  m_root;
	logic              m_neg;

	tbim_isqrt_pipe #(.RAD_W(46), .LANES(1), .SB_W(1)) u_msqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s8),
		.in_ready (m_in_ready),
		.in_rad   (m2_s8),
		.in_sb    (neg_s8),
		.out_valid(m_out_valid),
		.out_ready(m_out_ready),
		.out_root (m_root),
		.out_sb   (m_neg)
	);

	// ---------------------------------------------------------------------
	// Tail: S9 binning set-up, restoring divider, output register
	// ---------------------------------------------------------------------
	typedef struct packed {
		logic [MASS_IW-1:0]          rem;
		logic [QB-1:0]               q;
		logic                        neg;
		logic                        under;
		logic                        over;
		logic [tbim_pkg::MASS_W-1:0] mass;
	} drec_t;

	logic [QB:0] dv_q;
	logic [QB:0] en_d;
	drec_t       drec_s [QB+1];
	logic        out_v_q;
	logic        en_o;

	logic [23:0]        mass_rnd;
	logic [MASS_IW-1:0] mass_i;
	logic [MASS_IW-1:0] diff;

	assign mass_rnd = {1'b0, m_root[0]} + 24'd2;
	assign mass_i   = mass_rnd[23:2];
	assign diff     = mass_i - MASS_IW'(hlow_q);

	assign en_o = !out_v_q || result.ready;
	assign m_out_ready = en_d[0];

	// S9 sits at index zero of the divider chain
	assign en_d[0] = !dv_q[0] || ((QB > 0) ? en_d[1] : en_o);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q[0] <= 1'b0;
		end else if (en_d[0]) begin
			dv_q[0] <= m_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_d[0] && m_out_valid) begin
			drec_s[0].rem   <= diff;
			drec_s[0].q     <= '0;
			drec_s[0].neg   <= m_neg;
			drec_s[0].under <= mass_i < MASS_IW'(hlow_q);
			drec_s[0].over  <= diff >= MASS_IW'(nbw_q);
			// Saturate the reported mass; binning keeps the full value
			drec_s[0].mass  <= (mass_i > MASS_IW'(tbim_pkg::MASS_MAX))
				? tbim_pkg::MASS_MAX : mass_i[tbim_pkg::MASS_W-1:0];
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar j = 1; j <= QB; j++) begin : g_div
		logic               down_en;
		logic [MASS_IW-1:0] dsh;
		drec_t              nxt;

		if (j == QB) begin : g_last
			assign down_en = en_o;
		end else begin : g_mid
			assign down_en = en_d[j+1];
		end

		assign en_d[j] = !dv_q[j] || down_en;
		assign dsh     = MASS_IW'(wd_q) << (QB - j);

		always_comb begin
			nxt = drec_s[j-1];
			if (drec_s[j-1].rem >= dsh) begin
				nxt.rem       = drec_s[j-1].rem - dsh;
				nxt.q[QB - j] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_q[j] <= 1'b0;
			end else if (en_d[j]) begin
				dv_q[j] <= dv_q[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_d[j] && dv_q[j-1]) begin
				drec_s[j] <= nxt;
			end
		end
	end

	// Output register: holds a result until it is taken, upstream keeps filling empty stages
	logic [tbim_pkg::MASS_W-1:0] pair_mass_q;
	logic                        mass_valid_q;
	logic [tbim_pkg::CODE_W-1:0] bin_code_q;
	logic [8:0]                  code9;
	drec_t                       fin;

	assign fin = drec_s[QB];

	always_comb begin
		if (fin.neg || fin.under) begin
			code9 = '0;
		end else if (fin.over) begin
			code9 = OVF_CODE;
		end else begin
			code9 = 9'(fin.q) + 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_o) begin
			out_v_q <= dv_q[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && dv_q[QB]) begin
			pair_mass_q  <= fin.neg ? '0 : fin.mass;
			mass_valid_q <= !fin.neg;
			bin_code_q   <= code9[tbim_pkg::CODE_W-1:0];
		end
	end

	assign result.valid      = out_v_q;
	assign result.pair_mass  = pair_mass_q;
	assign result.mass_valid = mass_valid_q;
	assign result.bin_code   = bin_code_q;

endmodule

>>> src/tbim_checker.sv
module tbim_checker #(
	parameter int NUM_BINS = 50
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [tbim_pkg::MASS_W-1:0]       pair_mass,
	input logic                              mass_valid,
	input logic [tbim_pkg::CODE_W-1:0]       bin_code
);
	logic [15:0] pend_q;
	logic        in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 16'(in_acc) - 16'(out_acc);
		end
	end

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pair_mass)
			&& $stable(mass_valid) && $stable(bin_code))
		else $error("result changed while stalled");

	// Never a result without an outstanding request
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 16'd0)
		else $error("result without request");

	// Invalid mass reports zero mass and underflow code
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mass_valid |-> pair_mass == '0 && bin_code == '0)
		else $error("invalid mass not zeroed");

	// Bin code stays in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (NUM_BINS >= 63) || (32'(bin_code) <= NUM_BINS + 1))
		else $error("bin code out of range");

endmodule

bind two_body_invariant_mass tbim_checker #(.NUM_BINS(NUM_BINS)) u_tbim_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pair.valid),
	.in_ready  (pair.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.pair_mass (result.pair_mass),
	.mass_valid(result.mass_valid),
	.bin_code  (result.bin_code)
);

>>> tb/tbim_mass_checker.sv
module tbim_mass_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	tbim_pair_if.sink            pair_mon,
	tbim_result_if.sink          result_mon,
	tbim_cfg_if.sink             cfg_mon,
	output int                   fail_count,
	output int                   masses_pending
);
	localparam int BINS = 50;

	typedef struct packed {
		logic [tbim_pkg::MASS_W-1:0] pair_mass;
		logic                        mass_valid;
		logic [tbim_pkg::CODE_W-1:0] bin_code;
	} mass_result_t;

	mass_result_t expected_masses[$];

	logic [tbim_pkg::DM_W-1:0] dmass;
	logic [tbim_pkg::P_W-1:0]  pdefault;
	logic [tbim_pkg::P_W-1:0]  plimit;
	logic [tbim_pkg::HL_W-1:0] hlow;
	logic [tbim_pkg::BW_W-1:0] bwidth;

	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned sanitise(logic signed [tbim_pkg::MOM_W-1:0] raw);
		longint signed p;
		p = raw;
		if (p <= 0 || p >= longint'(plimit))
			return pdefault;
		return p;
	endfunction

	// round half up into 1/64 MeV; arithmetic shift gives floor
	function automatic longint signed proj(longint unsigned p,
		logic signed [tbim_pkg::COS_W-1:0] c);
		longint signed prod;
		prod = longint'(p) * longint'(c);
		return (prod + 2048) >>> 12;
	endfunction

	function automatic longint unsigned track_energy(longint unsigned p);
		longint unsigned m;
		m = dmass;
		return int_root((p * p + m * m) * 16);
	endfunction

	function automatic mass_result_t predict_mass(
		logic signed [tbim_pkg::MOM_W-1:0] m1, logic signed [tbim_pkg::COS_W-1:0] x1,
		logic signed [tbim_pkg::COS_W-1:0] y1, logic signed [tbim_pkg::COS_W-1:0] z1,
		logic signed [tbim_pkg::MOM_W-1:0] m2, logic signed [tbim_pkg::COS_W-1:0] x2,
		logic signed [tbim_pkg::COS_W-1:0] y2, logic signed [tbim_pkg::COS_W-1:0] z2);
		longint unsigned p1, p2, et, e2, psq, mass, w, idx, code;
		longint signed sx, sy, sz;
		mass_result_t r;
		p1 = sanitise(m1);
		p2 = sanitise(m2);
		sx = proj(p1, x1) + proj(p2, x2);
		sy = proj(p1, y1) + proj(p2, y2);
		sz = proj(p1, z1) + proj(p2, z2);
		et = track_energy(p1) + track_energy(p2);
		e2 = et * et;
		psq = longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz);
		r = '0;
		if (e2 < psq)
			return r;
		mass = (int_root(e2 - psq) + 2) >> 2;
		w = (bwidth == 0) ? 1 : bwidth;
		if (mass < hlow) begin
			code = 0;
		end else begin
			idx = (mass - hlow) / w;
			code = (idx >= BINS) ? BINS + 1 : idx + 1;
		end
		r.pair_mass  = (mass > tbim_pkg::MASS_MAX) ? tbim_pkg::MASS_MAX
			: mass[tbim_pkg::MASS_W-1:0];
		r.mass_valid = 1'b1;
		r.bin_code   = code[tbim_pkg::CODE_W-1:0];
		return r;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("%0t: %s mismatch: got %0d want %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmass    <= tbim_pkg::DM_RST;
			pdefault <= tbim_pkg::PDEF_RST;
			plimit   <= tbim_pkg::PLIM_RST;
			hlow     <= tbim_pkg::HLOW_RST;
			bwidth   <= tbim_pkg::BWID_RST;
		end else if (cfg_mon.valid && cfg_mon.ready) begin
			case (tbim_pkg::cfg_reg_t'(cfg_mon.idx))
				tbim_pkg::REG_DAUGHTER_MASS:
					dmass    <= cfg_mon.data[tbim_pkg::DM_W-1:0];
				tbim_pkg::REG_DEFAULT_MOMENTUM:
					pdefault <= cfg_mon.data[tbim_pkg::P_W-1:0];
				tbim_pkg::REG_MOMENTUM_LIMIT:
					plimit   <= cfg_mon.data[tbim_pkg::P_W-1:0];
				tbim_pkg::REG_HIST_LOW:
					hlow     <= cfg_mon.data[tbim_pkg::HL_W-1:0];
				tbim_pkg::REG_BIN_WIDTH:
					bwidth   <= cfg_mon.data[tbim_pkg::BW_W-1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		mass_result_t want;
		mass_result_t fresh;
		if (arst_n && pair_mon.valid && pair_mon.ready) begin
			fresh = predict_mass(
				pair_mon.momentum_first, pair_mon.dir_x_first,
				pair_mon.dir_y_first, pair_mon.dir_z_first,
				pair_mon.momentum_second, pair_mon.dir_x_second,
				pair_mon.dir_y_second, pair_mon.dir_z_second);
			expected_masses = {expected_masses, fresh};
		end
		if (arst_n && result_mon.valid && result_mon.ready) begin
			if (expected_masses.size() == 0) begin
				report("unexpected result", result_mon.pair_mass, 0);
			end else begin
				want = expected_masses.pop_front();
				if (result_mon.pair_mass !== want.pair_mass)
					report("pair_mass", result_mon.pair_mass, want.pair_mass);
				if (result_mon.mass_valid !== want.mass_valid)
					report("mass_valid", result_mon.mass_valid, want.mass_valid);
				if (result_mon.bin_code !== want.bin_code)
					report("bin_code", result_mon.bin_code, want.bin_code);
			end
		end
		masses_pending = expected_masses.size();
	end
endmodule

>>> tb/testbench.sv
module testbench;
	localparam int MW = tbim_pkg::MOM_W;
	localparam int SW = tbim_pkg::COS_W;
	localparam int CW = tbim_pkg::CFG_DATA_W;

	// allow plenty beyond the pipeline depth at NUM_BINS = 50
	localparam int DRAIN_CYCLES = 120;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   masses_pending;
	bit   stalls_on;

	tbim_pair_if   pair();
	tbim_result_if result();
	tbim_cfg_if    cfg();

	two_body_invariant_mass dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	tbim_mass_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.pair_mon       (pair.sink),
		.result_mon     (result.sink),
		.cfg_mon        (cfg.sink),
		.fail_count     (fail_count),
		.masses_pending (masses_pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Receiver back-pressure: a random pattern, sometimes switched off
	always @(negedge clk) begin
		if (!stalls_on)
			result.ready <= 1'b1;
		else
			result.ready <= ($urandom_range(0, 3) != 0);
	end

	// Draw a cosine: mostly in range, sometimes at the limits or raw 16-bit noise
	function automatic logic signed [SW-1:0] pick_cos();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return SW'($urandom());
			default: return SW'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	// Draw a momentum: mostly valid, with invalid, limit and raw values mixed in
	function automatic logic signed [MW-1:0] pick_mom();
		case ($urandom_range(0, 9))
			0: return MW'($urandom());
			1: return MW'(-$urandom_range(0, 524288));
			2: return '0;
			3: return MW'($urandom_range(150000, 170000));
			default: return MW'($urandom_range(1, 40000));
		endcase
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_pair(input logic signed [MW-1:0] m1, input logic signed [SW-1:0] x1,
		input logic signed [SW-1:0] y1, input logic signed [SW-1:0] z1,
		input logic signed [MW-1:0] m2, input logic signed [SW-1:0] x2,
		input logic signed [SW-1:0] y2, input logic signed [SW-1:0] z2);
		pair.valid           <= 1'b1;
		pair.momentum_first  <= m1;
		pair.dir_x_first     <= x1;
		pair.dir_y_first     <= y1;
		pair.dir_z_first     <= z1;
		pair.momentum_second <= m2;
		pair.dir_x_second    <= x2;
		pair.dir_y_second    <= y2;
		pair.dir_z_second    <= z2;
		do @(posedge clk); while (!pair.ready);
		@(negedge clk);
	endtask

	task automatic send_random_pair();
		send_pair(pick_mom(), pick_cos(), pick_cos(), pick_cos(),
			pick_mom(), pick_cos(), pick_cos(), pick_cos());
	endtask

	// Drop valid for a random gap between bursts
	task automatic idle_gap();
		int n;
		n = $urandom_range(1, 6);
		pair.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic write_reg(input tbim_pkg::cfg_reg_t which, input logic [CW-1:0] value);
		cfg.valid <= 1'b1;
		cfg.idx   <= which;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Wait until every prediction is matched, then let the pipeline settle
	task automatic drain();
		pair.valid <= 1'b0;
		while (masses_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_burst_phase(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst && left > 0; k++) begin
				send_random_pair();
				left--;
			end
			if ($urandom_range(0, 3) != 0)
				idle_gap();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		stalls_on       = 1'b0;
		pair.valid      = 1'b0;
		pair.momentum_first  = '0;
		pair.dir_x_first     = '0;
		pair.dir_y_first     = '0;
		pair.dir_z_first     = '0;
		pair.momentum_second = '0;
		pair.dir_x_second    = '0;
		pair.dir_y_second    = '0;
		pair.dir_z_second    = '0;
		cfg.valid       = 1'b0;
		cfg.idx         = '0;
		cfg.data        = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset settings, extremes and special cases
		send_pair(20'sd1000, 16'sd16384, '0, '0, 20'sd1000, -16'sd16384, '0, '0);
		send_pair(20'sd1000, 16'sd16384, '0, '0, 20'sd1000, 16'sd16384, '0, '0);
		send_pair(20'sd524287, 16'sd16384, 16'sd16384, 16'sd16384,
			20'sh80000, 16'sh8000, 16'sd32767, 16'sh8000);
		send_pair('0, '0, '0, '0, -20'sd1, '0, '0, '0);
		send_pair(20'sd159999, 16'sd16384, '0, '0, 20'sd160000, '0, 16'sd16384, '0);
		send_pair(20'sd1, 16'sd32767, 16'sd32767, 16'sd32767,
			20'sd1, 16'sd32767, 16'sd32767, 16'sd32767);
		send_pair(20'sd150000, 16'sd32767, 16'sd32767, 16'sd32767,
			20'sd150000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_pair(20'sd3200, '0, '0, 16'sd16384, 20'sd3200, '0, '0, -16'sd16384);
		send_pair(20'sd100, -16'sd1, 16'sd1, -16'sd1, 20'sd200, 16'sd1, -16'sd1, 16'sd1);
		drain();

		// Extremes: zero width, zero limit, heavy mass to saturate
		write_reg(tbim_pkg::REG_BIN_WIDTH, '0);
		write_reg(tbim_pkg::REG_MOMENTUM_LIMIT, '0);
		write_reg(tbim_pkg::REG_DEFAULT_MOMENTUM, 19'h7FFFF);
		write_reg(tbim_pkg::REG_DAUGHTER_MASS, 19'h0FFFF);
		write_reg(tbim_pkg::REG_HIST_LOW, '0);
		send_pair(20'sd5, 16'sd16384, '0, '0, 20'sd7, -16'sd16384, '0, '0);
		send_pair(20'sd5, 16'sd16384, '0, '0, 20'sd7, 16'sd16384, '0, '0);
		drain();

		write_reg(tbim_pkg::REG_BIN_WIDTH, 19'h00FFF);
		write_reg(tbim_pkg::REG_MOMENTUM_LIMIT, 19'h7FFFF);
		write_reg(tbim_pkg::REG_DEFAULT_MOMENTUM, '0);
		write_reg(tbim_pkg::REG_DAUGHTER_MASS, '0);
		write_reg(tbim_pkg::REG_HIST_LOW, 19'h3FFFF);
		send_pair(20'sd524286, 16'sd16384, '0, '0, 20'sd524286, -16'sd16384, '0, '0);
		send_pair('0, '0, '0, '0, '0, '0, '0, '0);
		send_pair(20'sd1, 16'sd16384, '0, '0, 20'sd1, 16'sd16384, '0, '0);
		send_random_pair();
		drain();

		// Random phases across several settings, stalls switched on except in one phase
		stalls_on = 1'b1;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0) begin
				write_reg(tbim_pkg::REG_DAUGHTER_MASS, CW'(tbim_pkg::DM_RST));
				write_reg(tbim_pkg::REG_DEFAULT_MOMENTUM, CW'(tbim_pkg::PDEF_RST));
				write_reg(tbim_pkg::REG_MOMENTUM_LIMIT, CW'(tbim_pkg::PLIM_RST));
				write_reg(tbim_pkg::REG_HIST_LOW, CW'(tbim_pkg::HLOW_RST));
				write_reg(tbim_pkg::REG_BIN_WIDTH, CW'(tbim_pkg::BWID_RST));
			end else begin
				write_reg(tbim_pkg::REG_DAUGHTER_MASS, CW'($urandom_range(0, 16'hFFFF)));
				write_reg(tbim_pkg::REG_DEFAULT_MOMENTUM, CW'($urandom_range(0, 19'h7FFFF)));
				write_reg(tbim_pkg::REG_MOMENTUM_LIMIT, CW'($urandom_range(1, 19'h7FFFF)));
				write_reg(tbim_pkg::REG_HIST_LOW, CW'($urandom_range(0, 60000)));
				write_reg(tbim_pkg::REG_BIN_WIDTH, CW'($urandom_range(1, 12'hFFF)));
			end
			stalls_on = (phase != 3);
			random_burst_phase(220);
			drain();
		end

		if (fail_count == 0)
			$display("two_body_invariant_mass test passed");
		else
			$display("two_body_invariant_mass test failed");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#400000;
		$display("two_body_invariant_mass test failed");
		$finish;
	end
endmodule
